// ----- rtl/core/bpa_pkg.sv -----
// Shared types and constants for the bitmap page allocator core.
// Holds the request/response payload structs, the sequencer states and the sizing constants.
// No dependencies.
package bpa_pkg;

	localparam int NUM_BLOCKS  = 4096;
	localparam int BLOCK_SHIFT = 12;
	localparam int BLOCK_BYTES = 1 << BLOCK_SHIFT;

	localparam int SIZE_W = 24;
	localparam int ADDR_W = 32;
	localparam int TB_W   = 13;
	localparam int CFG_W  = 32;

	// Map storage: one bit per block, packed into 32-bit rows.
	localparam int WORD_W = 32;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int IDX_W  = $clog2(NUM_BLOCKS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int ROW_W  = IDX_W - BIT_W;
	localparam int ROWS   = NUM_BLOCKS / WORD_W;

	// Block counts derived from sizes and addresses.
	localparam int NM1_W = SIZE_W - BLOCK_SHIFT;
	localparam int OFF_W = ADDR_W - BLOCK_SHIFT;
	localparam int RUN_W = ((NM1_W > CNT_W) ? NM1_W : CNT_W) + 1;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_BLOCKS = 1'b0,
		REG_POOL_BASE    = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SIZE_W-1:0] size_bytes;
		logic [ADDR_W-1:0] release_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] grant_address;
		logic              failed;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_RD,
		S_SCAN,
		S_FIT,
		S_MRD,
		S_MWR,
		S_REPORT
	} state_t;

endpackage

// ----- rtl/core/bpa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Used for the block usage map; no dependencies.
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/bitmap_page_allocator_core.sv -----
// Next-fit bitmap block allocator: sequencer, scan datapath and configuration registers.
// Depends on bpa_pkg and bpa_ram (usage map, 32 blocks per row).
// Sequence: an allocation sets up, then fetches map rows and scans them (a whole row inside the
// map that is fully used or fully free is passed at once, otherwise block by block, and the end
// of a lap is one more step), over up to two laps, then reads and writes each row it marks; a
// failed allocation skips the fit step and the marking. A release reads and writes each row cleared.
// One request at a time: busy stays high until the result strobe; the map RAM port and the
// single run counter set the rate. Reset clears the map by per-row valid bits at once, with
// no clearing pass; the result strobe cannot be stalled by the receiver.
module bitmap_page_allocator_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  bpa_pkg::req_t                         req,
	output logic                                  done,
	output bpa_pkg::rsp_t                         rsp,
	input  logic                                  cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bpa_pkg::CFG_W-1:0]             cfg_data
);

	bpa_pkg::state_t state_q, state_d;

	logic [bpa_pkg::TB_W-1:0]   total_blocks_q;
	logic [bpa_pkg::ADDR_W-1:0] pool_base_q;

	bpa_pkg::op_t               op_q;
	logic [bpa_pkg::NM1_W-1:0]  nm1_q;
	logic [bpa_pkg::OFF_W-1:0]  first_q;
	logic [bpa_pkg::CNT_W-1:0]  t_q;
	logic [bpa_pkg::IDX_W-1:0]  rover_q;
	logic [bpa_pkg::IDX_W-1:0]  start_q;
	logic [bpa_pkg::CNT_W-1:0]  pos_q;
	logic                       lap_q;
	logic [bpa_pkg::RUN_W-1:0]  run_len_q;
	logic [bpa_pkg::IDX_W-1:0]  run_start_q;
	logic [bpa_pkg::IDX_W-1:0]  s_q;
	logic                       fail_q;
	logic [bpa_pkg::IDX_W-1:0]  lo_q;
	logic [bpa_pkg::IDX_W-1:0]  last_q;
	logic [bpa_pkg::ROW_W-1:0]  wrow_q;
	logic [bpa_pkg::ROW_W-1:0]  rd_row_q;
	logic [bpa_pkg::ROWS-1:0]   row_vld_q;
	logic                       done_q;
	bpa_pkg::rsp_t              rsp_q;

	logic                       ram_we;
	logic                       ram_re;
	logic [bpa_pkg::ROW_W-1:0]  ram_raddr;
	logic [bpa_pkg::WORD_W-1:0] ram_rdata;
	logic [bpa_pkg::WORD_W-1:0] ram_wdata;

	logic                       accept;
	logic [bpa_pkg::WORD_W-1:0] word;
	logic                       at_end;
	logic                       whole;
	logic                       fast;
	logic                       grow;
	logic                       hit;
	logic                       lap_more;
	logic [bpa_pkg::CNT_W:0]    pos_plus_word;
	logic [bpa_pkg::CNT_W-1:0]  pos_next;
	logic [bpa_pkg::RUN_W-1:0]  need;
	logic [bpa_pkg::RUN_W-1:0]  run_next;
	logic [bpa_pkg::IDX_W-1:0]  cand;
	logic                       too_big;
	logic [bpa_pkg::IDX_W-1:0]  scan_start;
	logic                       rel_out;
	logic [bpa_pkg::OFF_W:0]    rel_sum;
	logic [bpa_pkg::IDX_W-1:0]  rel_last;
	logic [bpa_pkg::RUN_W-1:0]  fit_sum;
	logic [bpa_pkg::RUN_W-1:0]  fit_next;
	logic [bpa_pkg::WORD_W-1:0] mask;
	logic [bpa_pkg::IDX_W-1:0]  mask_idx;
	logic [bpa_pkg::CNT_W-1:0]  t_sat;

	bpa_ram #(
		.WIDTH(bpa_pkg::WORD_W),
		.DEPTH(bpa_pkg::ROWS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wrow_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Scan and range datapath.
	always_comb begin
		// A row that was never written since reset reads as all free.
		word = row_vld_q[rd_row_q] ? ram_rdata : '0;

		need          = bpa_pkg::RUN_W'(nm1_q) + bpa_pkg::RUN_W'(1);
		at_end        = (pos_q == t_q);
		pos_plus_word = {1'b0, pos_q} + (bpa_pkg::CNT_W+1)'(bpa_pkg::WORD_W);
		whole         = (pos_q[bpa_pkg::BIT_W-1:0] == '0) && (pos_plus_word <= {1'b0, t_q});
		fast          = whole && ((&word) || (~|word));
		grow          = fast ? (~|word) : !word[pos_q[bpa_pkg::BIT_W-1:0]];
		run_next      = run_len_q + (fast ? bpa_pkg::RUN_W'(bpa_pkg::WORD_W)
		                                  : bpa_pkg::RUN_W'(1));
		pos_next      = pos_q + (fast ? bpa_pkg::CNT_W'(bpa_pkg::WORD_W)
		                              : bpa_pkg::CNT_W'(1));
		cand          = (run_len_q == '0) ? pos_q[bpa_pkg::IDX_W-1:0] : run_start_q;
		hit           = !at_end && grow && (run_next >= need);
		lap_more      = !lap_q && (start_q != '0);

		too_big    = need > bpa_pkg::RUN_W'(t_q);
		scan_start = ({1'b0, rover_q} < t_q) ? rover_q : '0;

		// Releases clear only blocks below the end of the map, with no wrap.
		rel_out  = first_q >= bpa_pkg::OFF_W'(bpa_pkg::NUM_BLOCKS);
		rel_sum  = (bpa_pkg::OFF_W+1)'(first_q) + (bpa_pkg::OFF_W+1)'(nm1_q);
		rel_last = (rel_sum >= (bpa_pkg::OFF_W+1)'(bpa_pkg::NUM_BLOCKS - 1))
		           ? bpa_pkg::IDX_W'(bpa_pkg::NUM_BLOCKS - 1)
		           : rel_sum[bpa_pkg::IDX_W-1:0];

		fit_sum  = bpa_pkg::RUN_W'(s_q) + bpa_pkg::RUN_W'(nm1_q);
		fit_next = fit_sum + bpa_pkg::RUN_W'(1);

		if (32'(total_blocks_q) == 32'd0) begin
			t_sat = bpa_pkg::CNT_W'(1);
		end else if (32'(total_blocks_q) > 32'(bpa_pkg::NUM_BLOCKS)) begin
			t_sat = bpa_pkg::CNT_W'(bpa_pkg::NUM_BLOCKS);
		end else begin
			t_sat = bpa_pkg::CNT_W'(total_blocks_q);
		end

		mask_idx = '0;
		for (int j = 0; j < bpa_pkg::WORD_W; j++) begin
			mask_idx = {wrow_q, bpa_pkg::BIT_W'(j)};
			mask[j]  = (mask_idx >= lo_q) && (mask_idx <= last_q);
		end
		ram_wdata = (op_q == bpa_pkg::OP_ALLOC) ? (word | mask) : (word & ~mask);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (accept) begin
					state_d = bpa_pkg::S_SETUP;
				end
			end
			bpa_pkg::S_SETUP: begin
				if (op_q == bpa_pkg::OP_RELEASE) begin
					state_d = rel_out ? bpa_pkg::S_REPORT : bpa_pkg::S_MRD;
				end else begin
					state_d = too_big ? bpa_pkg::S_REPORT : bpa_pkg::S_RD;
				end
			end
			bpa_pkg::S_RD: begin
				state_d = bpa_pkg::S_SCAN;
			end
			bpa_pkg::S_SCAN: begin
				if (at_end) begin
					state_d = lap_more ? bpa_pkg::S_RD : bpa_pkg::S_REPORT;
				end else if (hit) begin
					state_d = bpa_pkg::S_FIT;
				end else if (fast || (pos_next[bpa_pkg::BIT_W-1:0] == '0)) begin
					state_d = bpa_pkg::S_RD;
				end
			end
			bpa_pkg::S_FIT: begin
				state_d = bpa_pkg::S_MRD;
			end
			bpa_pkg::S_MRD: begin
				state_d = bpa_pkg::S_MWR;
			end
			bpa_pkg::S_MWR: begin
				state_d = (wrow_q == last_q[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W])
				          ? bpa_pkg::S_REPORT : bpa_pkg::S_MRD;
			end
			bpa_pkg::S_REPORT: begin
				state_d = bpa_pkg::S_IDLE;
			end
			default: begin
				state_d = bpa_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy      = 1'b1;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = pos_q[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W];
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				busy = 1'b0;
			end
			bpa_pkg::S_RD: begin
				ram_re = 1'b1;
			end
			bpa_pkg::S_MRD: begin
				ram_re    = 1'b1;
				ram_raddr = wrow_q;
			end
			bpa_pkg::S_MWR: begin
				ram_we = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bpa_pkg::S_IDLE;
			total_blocks_q <= bpa_pkg::TB_W'(bpa_pkg::NUM_BLOCKS);
			pool_base_q    <= 32'h0010_0000;
			rover_q        <= '0;
			row_vld_q      <= '0;
			done_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == bpa_pkg::S_REPORT);
			if (cfg_we) begin
				unique case (cfg_index)
					bpa_pkg::REG_TOTAL_BLOCKS: total_blocks_q <= cfg_data[bpa_pkg::TB_W-1:0];
					bpa_pkg::REG_POOL_BASE:    pool_base_q    <= cfg_data[bpa_pkg::ADDR_W-1:0];
					default:                   pool_base_q    <= pool_base_q;
				endcase
			end
			if (ram_we) begin
				row_vld_q[wrow_q] <= 1'b1;
			end
			if (state_q == bpa_pkg::S_FIT) begin
				rover_q <= (fit_next == bpa_pkg::RUN_W'(t_q))
				           ? '0 : fit_next[bpa_pkg::IDX_W-1:0];
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_row_q <= ram_raddr;
		end
		unique case (state_q)
			bpa_pkg::S_IDLE: begin
				if (accept) begin
					op_q    <= req.op;
					nm1_q   <= req.size_bytes[bpa_pkg::SIZE_W-1:bpa_pkg::BLOCK_SHIFT];
					first_q <= bpa_pkg::OFF_W'((req.release_address - pool_base_q)
					                           >> bpa_pkg::BLOCK_SHIFT);
					t_q     <= t_sat;
					fail_q  <= 1'b0;
				end
			end
			bpa_pkg::S_SETUP: begin
				if (op_q == bpa_pkg::OP_RELEASE) begin
					lo_q   <= first_q[bpa_pkg::IDX_W-1:0];
					last_q <= rel_last;
					wrow_q <= first_q[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W];
				end else begin
					fail_q    <= too_big;
					start_q   <= scan_start;
					pos_q     <= {1'b0, scan_start};
					lap_q     <= 1'b0;
					run_len_q <= '0;
				end
			end
			bpa_pkg::S_SCAN: begin
				if (at_end) begin
					// A second lap covers the starts below the rover.
					if (lap_more) begin
						lap_q     <= 1'b1;
						pos_q     <= '0;
						run_len_q <= '0;
					end else begin
						fail_q <= 1'b1;
					end
				end else if (hit) begin
					s_q <= cand;
				end else begin
					pos_q <= pos_next;
					if (grow) begin
						run_len_q   <= run_next;
						run_start_q <= cand;
					end else begin
						run_len_q <= '0;
					end
				end
			end
			bpa_pkg::S_FIT: begin
				lo_q   <= s_q;
				last_q <= fit_sum[bpa_pkg::IDX_W-1:0];
				wrow_q <= s_q[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W];
			end
			bpa_pkg::S_MWR: begin
				wrow_q <= wrow_q + bpa_pkg::ROW_W'(1);
			end
			bpa_pkg::S_REPORT: begin
				rsp_q.failed <= fail_q;
				if ((op_q == bpa_pkg::OP_ALLOC) && !fail_q) begin
					rsp_q.grant_address <= pool_base_q
					                       + (bpa_pkg::ADDR_W'(s_q) << bpa_pkg::BLOCK_SHIFT);
				end else begin
					rsp_q.grant_address <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	// An accepted request keeps the block busy into the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request transfer did not make the block busy");

	// The result strobe follows only the report step of the sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == bpa_pkg::S_REPORT))
		else $error("result strobe without a finished request");

	// A failed allocation never carries an address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.failed) |-> (rsp.grant_address == '0))
		else $error("failed result carries a nonzero address");

	// While scanning, the open run is shorter than the request and the position stays in range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bpa_pkg::S_SCAN) |-> ((run_len_q < need) && (pos_q <= t_q)))
		else $error("scan run counter or position out of range");

endmodule
